FILE: rtl/core/rgb2yuv_pkg.sv
// Shared types, constants and register map of the RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps

package rgb2yuv_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned CfgW   = 13;
  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned WSizeW = $clog2(MaxWidth + 1);
  localparam int unsigned HSizeW = $clog2(MaxHeight + 1);

  localparam int unsigned CompW  = 8;
  localparam int unsigned InDataW  = 3 * CompW;
  localparam int unsigned OutDataW = 2 * CompW;
  localparam int unsigned OutUserW = 3;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CHROMA_NONE = 2'd0,
    CHROMA_CB   = 2'd1,
    CHROMA_CR   = 2'd2
  } chroma_kind_e;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    chroma_kind_e kind;
    logic         row_end;
    logic         frame_end;
  } pix_ctrl_t;

endpackage

FILE: rtl/core/rgb2yuv_csc.sv
// Combinational BT.601 studio-range color conversion of one pixel.
`timescale 1ns / 1ps

module rgb2yuv_csc (
  input  rgb2yuv_pkg::pixel_t                   pixel_i,
  input  rgb2yuv_pkg::chroma_kind_e             kind_i,
  output logic [rgb2yuv_pkg::CompW-1:0]         luma_o,
  output logic [rgb2yuv_pkg::CompW-1:0]         chroma_o
);
  import rgb2yuv_pkg::*;

  logic [17:0] r_ext, g_ext, b_ext;
  logic [17:0] y_sum, cb_sum, cr_sum;

  assign r_ext = {10'd0, pixel_i.red};
  assign g_ext = {10'd0, pixel_i.green};
  assign b_ext = {10'd0, pixel_i.blue};

  // All sums are two's complement modulo 2^18; the true values fit in 17 bits.
  assign y_sum  = r_ext * 18'd66 + g_ext * 18'd129 + b_ext * 18'd25 + 18'd128;
  assign cb_sum = b_ext * 18'd112 - r_ext * 18'd38 - g_ext * 18'd74 + 18'd128;
  assign cr_sum = r_ext * 18'd112 - g_ext * 18'd94 - b_ext * 18'd18 + 18'd128;

  assign luma_o = y_sum[15:8] + 8'd16;

  always_comb begin
    case (kind_i)
      CHROMA_CB: chroma_o = cb_sum[15:8] + 8'd128;
      CHROMA_CR: chroma_o = cr_sum[15:8] + 8'd128;
      default:   chroma_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/rgb_to_yuv420_converter_unit.sv
// Top level of the RGB to YCbCr 4:2:0 converter with stream ports and APB registers.
`timescale 1ns / 1ps

// Converts one 24-bit RGB pixel per transaction, in raster order, into BT.601 studio-range
// luma plus decimated chroma: Cb on even columns of even rows, Cr on even columns of
// odd rows. One result leaves for every pixel, and the unit sustains one pixel per
// clock while the sink is ready; a pixel passes an input register and an output register
// before its result is offered. tlast marks the last pixel of a row and tuser
// bit 2 the last pixel of the frame. Frame width and height are set over APB at
// addresses 0x0 and 0x4; the user must write them only while the stream is idle, which
// the block does not enforce. Only the low 13 bits are stored; zero counts as one and
// stored values above 4096 saturate to 4096.

module rgb_to_yuv420_converter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rgb2yuv_pkg::InDataW-1:0]     s_axis_tdata,  // blue, green, red
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rgb2yuv_pkg::OutDataW-1:0]    m_axis_tdata,  // luma, chroma
  output logic                                m_axis_tlast,  // row_end
  output logic [rgb2yuv_pkg::OutUserW-1:0]    m_axis_tuser,  // chroma_kind[1:0], frame_end
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgb2yuv_pkg::ApbAddrW-1:0]    paddr,
  input  logic [rgb2yuv_pkg::ApbDataW-1:0]    pwdata,
  output logic [rgb2yuv_pkg::ApbDataW-1:0]    prdata,
  output logic                                pready
);
  import rgb2yuv_pkg::*;

  logic [CfgW-1:0]   width_q, height_q;
  logic [WSizeW-1:0] width_eff;
  logic [HSizeW-1:0] height_eff;
  logic              cfg_wr;
  reg_idx_e          reg_idx;

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;

  logic              s_accept, s1_advance;
  pix_ctrl_t         ctrl_now;

  logic              s1_valid_q;
  pixel_t            s1_pixel_q;
  pix_ctrl_t         s1_ctrl_q;

  logic [CompW-1:0]  luma, chroma;

  logic              out_valid_q;
  logic [CompW-1:0]  out_luma_q, out_chroma_q;
  pix_ctrl_t         out_ctrl_q;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(1920);
      height_q <= CfgW'(1080);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  width_q  <= pwdata[CfgW-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = ApbDataW'(width_q);
      REG_FRAME_HEIGHT: prdata = ApbDataW'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      width_eff = WSizeW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      width_eff = WSizeW'(MaxWidth);
    end else begin
      width_eff = WSizeW'(width_q);
    end
    if (height_q == '0) begin
      height_eff = HSizeW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      height_eff = HSizeW'(MaxHeight);
    end else begin
      height_eff = HSizeW'(height_q);
    end
  end

  assign s1_advance    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl_now.row_end   = (WSizeW'(col_q) + WSizeW'(1)) >= width_eff;
    ctrl_now.frame_end = ctrl_now.row_end && ((HSizeW'(row_q) + HSizeW'(1)) >= height_eff);
    if (col_q[0]) begin
      ctrl_now.kind = CHROMA_NONE;
    end else if (row_q[0]) begin
      ctrl_now.kind = CHROMA_CR;
    end else begin
      ctrl_now.kind = CHROMA_CB;
    end
    col_d = col_q;
    row_d = row_q;
    if (s_accept) begin
      if (ctrl_now.row_end) begin
        col_d = '0;
        row_d = ctrl_now.frame_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_pixel_q <= pixel_t'{red:   s_axis_tdata[23:16],
                             green: s_axis_tdata[15:8],
                             blue:  s_axis_tdata[7:0]};
      s1_ctrl_q  <= ctrl_now;
    end
    if (s1_advance && s1_valid_q) begin
      out_luma_q   <= luma;
      out_chroma_q <= chroma;
      out_ctrl_q   <= s1_ctrl_q;
    end
  end

  rgb2yuv_csc u_csc (
    .pixel_i  (s1_pixel_q),
    .kind_i   (s1_ctrl_q.kind),
    .luma_o   (luma),
    .chroma_o (chroma)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_chroma_q, out_luma_q};
  assign m_axis_tlast  = out_ctrl_q.row_end;
  assign m_axis_tuser  = {out_ctrl_q.frame_end, out_ctrl_q.kind};

  a_frame_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
    else $error("frame end without row end");

  a_no_chroma_value_without_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == CHROMA_NONE) |-> m_axis_tdata[15:8] == '0)
    else $error("chroma value set on a pixel without chroma");

  a_counters_wrap_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && ctrl_now.frame_end |=> (col_q == '0) && (row_q == '0))
    else $error("position counters did not return to zero after frame end");

  a_chroma_only_on_even_columns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (s1_ctrl_q.kind == CHROMA_NONE) == $past(col_q[0]))
    else $error("chroma kind does not follow column parity");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking stream testbench for the RGB to YCbCr 4:2:0 converter unit.
`timescale 1ns / 1ps

module testbench;
  import rgb2yuv_pkg::*;

  typedef struct packed {
    logic [CompW-1:0] luma;
    logic [CompW-1:0] chroma;
    chroma_kind_e     kind;
    logic             row_end;
    logic             frame_end;
  } yuv_result_t;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_SET_WIDTH,
    STEP_SET_HEIGHT
  } step_kind_e;

  typedef struct packed {
    step_kind_e     kind;
    logic [CfgW-1:0] size;
    pixel_t          pixel;
    logic            typed;
    yuv_result_t     result;
  } directed_step_t;

  localparam yuv_result_t Unchecked = '{8'd0, 8'd0, CHROMA_NONE, 1'b0, 1'b0};
  localparam int WatchdogLimit = 2000;
  localparam int RandomPixels = 550;

  localparam directed_step_t DirectedSteps[29] = '{
    '{STEP_PIXEL, 13'd0, 24'h000000, 1'b1, '{8'd16, 8'd128, CHROMA_CB, 1'b0, 1'b0}},
    '{STEP_PIXEL, 13'd0, 24'hFFFFFF, 1'b1, '{8'd235, 8'd0, CHROMA_NONE, 1'b0, 1'b0}},
    '{STEP_PIXEL, 13'd0, 24'h0000FF, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'hFF0000, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'hFFFF00, 1'b0, Unchecked},
    '{STEP_SET_WIDTH, 13'd4, 24'h000000, 1'b0, Unchecked},
    '{STEP_SET_HEIGHT, 13'd2, 24'h000000, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h00FF00, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'hFF0000, 1'b1, '{8'd82, 8'd240, CHROMA_CR, 1'b0, 1'b0}},
    '{STEP_PIXEL, 13'd0, 24'h00FFFF, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h00FFFF, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h808080, 1'b0, Unchecked},
    '{STEP_SET_WIDTH, 13'd0, 24'h000000, 1'b0, Unchecked},
    '{STEP_SET_HEIGHT, 13'd0, 24'h000000, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h000000, 1'b1, '{8'd16, 8'd128, CHROMA_CB, 1'b1, 1'b1}},
    '{STEP_PIXEL, 13'd0, 24'hFFFFFF, 1'b1, '{8'd235, 8'd128, CHROMA_CB, 1'b1, 1'b1}},
    '{STEP_SET_WIDTH, 13'd8191, 24'h000000, 1'b0, Unchecked},
    '{STEP_SET_HEIGHT, 13'd4097, 24'h000000, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h123456, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'hA5C3E1, 1'b0, Unchecked},
    '{STEP_SET_WIDTH, 13'd3, 24'h000000, 1'b0, Unchecked},
    '{STEP_SET_HEIGHT, 13'd3, 24'h000000, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h5A0F77, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h0F5AC8, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'hF0E1D2, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h3C3C3C, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'hC8000F, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h01FE7F, 1'b0, Unchecked},
    '{STEP_PIXEL, 13'd0, 24'h80FF01, 1'b0, Unchecked}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic [CfgW-1:0] width_reg = CfgW'(1920);
  logic [CfgW-1:0] height_reg = CfgW'(1080);
  int              pixel_col = 0;
  int              pixel_row = 0;
  yuv_result_t     expected_q[$];
  int              error_count = 0;
  int              idle_cycles = 0;
  bit              source_gaps_on = 1'b1;
  bit              sink_stalls_on = 1'b1;
  int              stall_left = 0;

  rgb_to_yuv420_converter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int frame_extent(logic [CfgW-1:0] size, int limit);
    if (size == 0) return 1;
    if (int'(size) > limit) return limit;
    return int'(size);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 24);
    return $urandom_range(1, 3);
  endfunction

  function automatic yuv_result_t convert_pixel(pixel_t px);
    int r;
    int g;
    int b;
    yuv_result_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    res.luma = CompW'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
    res.chroma = '0;
    res.kind = CHROMA_NONE;
    if (pixel_col % 2 == 0) begin
      if (pixel_row % 2 == 0) begin
        res.chroma = CompW'(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
        res.kind = CHROMA_CB;
      end else begin
        res.chroma = CompW'(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
        res.kind = CHROMA_CR;
      end
    end
    res.row_end = (pixel_col + 1) >= frame_extent(width_reg, MaxWidth);
    res.frame_end = res.row_end && ((pixel_row + 1) >= frame_extent(height_reg, MaxHeight));
    if (res.row_end) begin
      pixel_col = 0;
      pixel_row = res.frame_end ? 0 : pixel_row + 1;
    end else begin
      pixel_col = pixel_col + 1;
    end
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = pixel_t'($urandom());
    if ($urandom_range(0, 9) == 0) begin
      px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  task automatic send_pixel(pixel_t px, logic typed, yuv_result_t typed_res);
    yuv_result_t res;
    int gap;
    @(negedge clk_i);
    if (source_gaps_on && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    res = convert_pixel(px);
    expected_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic check_register(reg_idx_e idx, logic [ApbDataW-1:0] want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field(idx == REG_FRAME_WIDTH ? "frame_width" : "frame_height", want, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(reg_idx_e idx, logic [ApbDataW-1:0] value);
    drain_stream();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_FRAME_WIDTH) width_reg = value[CfgW-1:0];
    else height_reg = value[CfgW-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_register(idx, ApbDataW'(value[CfgW-1:0]));
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    yuv_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result transaction with no expectation pending", $time);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("luma", want.luma, m_axis_tdata[CompW-1:0]);
        check_field("chroma", want.chroma, m_axis_tdata[2*CompW-1:CompW]);
        check_field("chroma_kind", want.kind, m_axis_tuser[1:0]);
        check_field("row_end", want.row_end, m_axis_tlast);
        check_field("frame_end", want.frame_end, m_axis_tuser[2]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int count;
    int pick;
    logic [CfgW-1:0] new_width;
    logic [CfgW-1:0] new_height;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    check_register(REG_FRAME_WIDTH, ApbDataW'(1920));
    check_register(REG_FRAME_HEIGHT, ApbDataW'(1080));

    foreach (DirectedSteps[i]) begin
      case (DirectedSteps[i].kind)
        STEP_SET_WIDTH: begin
          write_register(REG_FRAME_WIDTH, ApbDataW'(DirectedSteps[i].size));
        end
        STEP_SET_HEIGHT: begin
          write_register(REG_FRAME_HEIGHT, ApbDataW'(DirectedSteps[i].size));
        end
        default: begin
          send_pixel(DirectedSteps[i].pixel, DirectedSteps[i].typed, DirectedSteps[i].result);
        end
      endcase
    end

    sent = 0;
    while (sent < RandomPixels) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        new_width = CfgW'($urandom_range(2, 12));
        new_height = CfgW'($urandom_range(2, 6));
      end else if (pick < 80) begin
        new_width = CfgW'($urandom_range(0, 3));
        new_height = CfgW'($urandom_range(0, 3));
      end else if (pick < 90) begin
        new_width = $urandom_range(0, 1) ? CfgW'(MaxWidth) : CfgW'($urandom_range(4097, 8191));
        new_height = CfgW'($urandom_range(2, 8));
      end else begin
        new_width = CfgW'($urandom_range(2, 8));
        new_height = $urandom_range(0, 1) ? CfgW'(MaxHeight) : CfgW'($urandom_range(4097, 8191));
      end
      write_register(REG_FRAME_WIDTH, ApbDataW'(new_width));
      write_register(REG_FRAME_HEIGHT, ApbDataW'(new_height));
      source_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, 20);
      end else begin
        count = frame_extent(new_width, MaxWidth) * frame_extent(new_height, MaxHeight) *
                $urandom_range(1, 2);
      end
      if (count > 60) count = 60;
      for (int i = 0; i < count; i++) begin
        if (i == count / 2 && $urandom_range(0, 3) == 0) drain_stream();
        send_pixel(random_pixel(), 1'b0, Unchecked);
      end
      sent += count;
    end

    drain_stream();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
